@@ rtl/lmts_pkg.sv @@
// shared types and constants for the lcd mode timing sequencer
package lmts_pkg;

  localparam int LEN_W     = 10;
  localparam int LINE_W    = 8;
  localparam int ACC_W     = 11;
  localparam int FRAME_W   = 16;
  localparam int ELAPSED_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;
  localparam int STEP_W    = 3;

  localparam logic [LEN_W-1:0]  MIN_LENGTH      = LEN_W'(16);
  localparam logic [LINE_W-1:0] MAX_VISIBLE     = LINE_W'(153);
  localparam logic [LINE_W-1:0] LINES_PER_FRAME = LINE_W'(154);

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lmts_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_UPDATE
  } lmts_state_t;

  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OAM_LEN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XFER_LEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_CMP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_IRQ_EN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_EN = 3'd7;

  // lengths below the minimum count as the minimum
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    eff_len = (v < MIN_LENGTH) ? MIN_LENGTH : v;
  endfunction

endpackage

@@ rtl/lmts_if.sv @@
// valid/ready channel interfaces for tick input, result output and config writes
interface lmts_in_if;
  import lmts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed;
  modport source (output valid, output elapsed, input ready);
  modport sink   (input valid, input elapsed, output ready);
endinterface

interface lmts_out_if;
  import lmts_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [LINE_W-1:0]  scanline;
  logic               line_match;
  logic               vblank_irq;
  logic               stat_irq;
  logic               frame_done;
  logic [FRAME_W-1:0] frame_count;
  modport source (output valid, output mode, output scanline, output line_match,
                  output vblank_irq, output stat_irq, output frame_done,
                  output frame_count, input ready);
  modport sink   (input valid, input mode, input scanline, input line_match,
                  input vblank_irq, input stat_irq, input frame_done,
                  input frame_count, output ready);
endinterface

interface lmts_cfg_if;
  import lmts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/lmts_mod_unit.sv @@
// shift-and-subtract remainder unit, one quotient bit per cycle
module lmts_mod_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [lmts_pkg::ACC_W-1:0] num,
  input  logic [lmts_pkg::LEN_W-1:0] den,
  output logic                     done,
  output logic [lmts_pkg::ACC_W-1:0] rem
);
  import lmts_pkg::*;

  localparam int CMP_W = ACC_W + 6;

  logic              running;
  logic [STEP_W-1:0] step;
  logic [LEN_W-1:0]  den_q;
  logic [CMP_W-1:0]  shifted;
  logic              fits;

  // divisor >= 16 so 8 quotient bits cover any 11-bit remainder
  assign shifted = {{(CMP_W-LEN_W){1'b0}}, den_q} << step;
  assign fits    = {{(CMP_W-ACC_W){1'b0}}, rem} >= shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '1;
      end else if (running) begin
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_q <= den;
    end else if (running && fits) begin
      rem <= rem - shifted[ACC_W-1:0];
    end
  end

endmodule

@@ rtl/lcd_mode_timing_sequencer.sv @@
// lcd mode timing sequencer top level
//
// in_ch carries one transaction per group of elapsed clock ticks; each one
// yields exactly one result transaction on out_ch with the display mode,
// scanline, stored line match flag, interrupt pulses and frame count.
// cfg writes one of eight registers by index; it is always ready. The user
// writes it only while the block is idle; the block does not enforce it.
// The sequencer steps through check and update when the accumulated ticks
// stay inside the current mode, and through check, reduce and update when
// the mode ends, because the remainder is then taken by a single
// shift-and-subtract unit that resolves one quotient bit per cycle. Input
// is taken again once the result is loaded, one item at a time.
// The result sits in an output register; a new input is accepted while it
// waits, but the next result is held until the receiver takes the pending
// one, so a stalled receiver stops the block after one more item.
// Reset loads the register defaults (204, 456, 80, 172, 144, 0, 0, 0) and
// clears mode to hblank, line, tick count, match flag and frame count.
module lcd_mode_timing_sequencer (
  input  logic       clk,
  input  logic       rst,
  lmts_in_if.sink    in_ch,
  lmts_out_if.source out_ch,
  lmts_cfg_if.sink   cfg
);
  import lmts_pkg::*;

  // configuration registers
  logic [LEN_W-1:0]  hblank_length;
  logic [LEN_W-1:0]  line_length;
  logic [LEN_W-1:0]  oam_length;
  logic [LEN_W-1:0]  transfer_length;
  logic [LINE_W-1:0] visible_lines;
  logic [LINE_W-1:0] line_compare;
  logic              match_irq_enable;
  logic              hblank_irq_enable;

  // timing state
  lmts_mode_t         current_mode;
  logic [LINE_W-1:0]  line_counter;
  logic [ACC_W-1:0]   tick_accumulator;
  logic               match_flag;
  logic [FRAME_W-1:0] frames_completed;

  lmts_state_t       state, state_next;
  logic [LEN_W-1:0]  len_cur;
  logic              mode_end;

  logic              mod_start;
  logic              mod_done;
  logic [ACC_W-1:0]  mod_rem;

  logic              out_free;
  logic              do_update;

  lmts_mode_t         mode_next;
  logic [LINE_W-1:0]  line_next;
  logic               match_next;
  logic [FRAME_W-1:0] frames_next;
  logic               vblank_pulse, stat_pulse, frame_pulse;
  logic [LINE_W-1:0]  line_inc;
  logic [LINE_W-1:0]  vis;
  logic               hit;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = (state == ST_IDLE);
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign do_update   = (state == ST_UPDATE) && out_free;
  assign mod_start   = (state == ST_CHECK) && (tick_accumulator >= {1'b0, len_cur});

  lmts_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .num  (tick_accumulator),
    .den  (len_cur),
    .done (mod_done),
    .rem  (mod_rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hblank_length     <= LEN_W'(204);
      line_length       <= LEN_W'(456);
      oam_length        <= LEN_W'(80);
      transfer_length   <= LEN_W'(172);
      visible_lines     <= LINE_W'(144);
      line_compare      <= '0;
      match_irq_enable  <= 1'b0;
      hblank_irq_enable <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_HBLANK_LEN:    hblank_length     <= cfg.data;
        REG_LINE_LEN:      line_length       <= cfg.data;
        REG_OAM_LEN:       oam_length        <= cfg.data;
        REG_XFER_LEN:      transfer_length   <= cfg.data;
        REG_VISIBLE:       visible_lines     <= cfg.data[LINE_W-1:0];
        REG_LINE_CMP:      line_compare      <= cfg.data[LINE_W-1:0];
        REG_MATCH_IRQ_EN:  match_irq_enable  <= cfg.data[0];
        REG_HBLANK_IRQ_EN: hblank_irq_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_ch.valid) state_next = ST_CHECK;
      ST_CHECK:  state_next = mod_start ? ST_REDUCE : ST_UPDATE;
      ST_REDUCE: if (mod_done) state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // mode transition outputs
  assign vis      = (visible_lines > MAX_VISIBLE) ? MAX_VISIBLE : visible_lines;
  assign line_inc = line_counter + LINE_W'(1);
  assign hit      = (line_compare == line_counter);

  always_comb begin
    mode_next    = current_mode;
    line_next    = line_counter;
    match_next   = match_flag;
    frames_next  = frames_completed;
    vblank_pulse = 1'b0;
    stat_pulse   = 1'b0;
    frame_pulse  = 1'b0;
    if (mode_end) begin
      unique case (current_mode)
        MODE_HBLANK: begin
          line_next = line_inc;
          if (line_inc >= vis) begin
            mode_next    = MODE_VBLANK;
            vblank_pulse = 1'b1;
          end else begin
            mode_next = MODE_OAM;
          end
        end
        MODE_VBLANK: begin
          if (line_inc >= LINES_PER_FRAME) begin
            line_next   = '0;
            frames_next = frames_completed + FRAME_W'(1);
            frame_pulse = 1'b1;
            mode_next   = MODE_OAM;
          end else begin
            line_next = line_inc;
          end
        end
        MODE_OAM: mode_next = MODE_XFER;
        MODE_XFER: begin
          mode_next  = MODE_HBLANK;
          stat_pulse = (match_irq_enable && hit) || hblank_irq_enable;
          match_next = hit;
        end
        default: mode_next = current_mode;
      endcase
    end
  end

  // accumulator, mode length capture and timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode     <= MODE_HBLANK;
      line_counter     <= '0;
      tick_accumulator <= '0;
      match_flag       <= 1'b0;
      frames_completed <= '0;
      mode_end         <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tick_accumulator <= tick_accumulator + {{(ACC_W-ELAPSED_W){1'b0}}, in_ch.elapsed};
        mode_end         <= 1'b0;
      end
      if (mod_done) begin
        tick_accumulator <= mod_rem;
        mode_end         <= 1'b1;
      end
      if (do_update) begin
        current_mode     <= mode_next;
        line_counter     <= line_next;
        match_flag       <= match_next;
        frames_completed <= frames_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      case (current_mode)
        MODE_HBLANK: len_cur <= eff_len(hblank_length);
        MODE_VBLANK: len_cur <= eff_len(line_length);
        MODE_OAM:    len_cur <= eff_len(oam_length);
        default:     len_cur <= eff_len(transfer_length);
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (do_update) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      out_ch.mode        <= mode_next;
      out_ch.scanline    <= line_next;
      out_ch.line_match  <= match_next;
      out_ch.vblank_irq  <= vblank_pulse;
      out_ch.stat_irq    <= stat_pulse;
      out_ch.frame_done  <= frame_pulse;
      out_ch.frame_count <= frames_next;
    end
  end

endmodule

@@ rtl/lmts_checker.sv @@
// port-level checks for the lcd mode timing sequencer, bound to the top level
module lmts_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_mode,
  input logic [7:0] out_scanline,
  input logic       out_vblank_irq,
  input logic       out_stat_irq,
  input logic       out_frame_done
);
  import lmts_pkg::*;

  // a result waiting on the receiver stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // after an input transaction the block is busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_vblank_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_vblank_irq |-> out_mode == MODE_VBLANK)
    else $error("vblank interrupt outside vblank");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_done |-> out_mode == MODE_OAM && out_scanline == '0)
    else $error("frame end without wrap to line zero in oam search");

  a_stat_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stat_irq |-> out_mode == MODE_HBLANK)
    else $error("stat interrupt outside hblank entry");

endmodule

bind lcd_mode_timing_sequencer lmts_checker u_lmts_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_mode      (out_ch.mode),
  .out_scanline  (out_ch.scanline),
  .out_vblank_irq(out_ch.vblank_irq),
  .out_stat_irq  (out_ch.stat_irq),
  .out_frame_done(out_ch.frame_done)
);
